FILE: hw/rtl/consistent_hash_ring_top_assert.svh
// Assertion macros for the hash ring block
`ifndef CONSISTENT_HASH_RING_TOP_ASSERT_SVH
`define CONSISTENT_HASH_RING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CHR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CHR_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/chr_pkg.sv
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types and codes for the hash ring controller and datapath.
// ----------------------------------------------------------------------------
package chr_pkg;
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;  // unused code, answered with the ring size

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOSERVER = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_SWAIT, S_LKRD, S_SHIFT, S_SCAN, S_DONE
   } state_type;

   typedef struct packed {
      logic load;       // capture request word
      logic srch_init;  // lo=0, hi=count
      logic srch_rd;    // issue read at mid
      logic srch_step;  // narrow with read data
      logic lk_rd;      // read the found entry
      logic sh_init;
      logic sh_step;
      logic scan_init;
      logic scan_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic srch_done;
      logic sh_done;
      logic scan_done;
      logic empty;
      logic full;
   } sts_type;
endpackage

FILE: hw/rtl/chr_ctrl.sv
// ----------------------------------------------------------------------------
// chr_ctrl
// Sequencer for lookup, add and remove.
// ----------------------------------------------------------------------------
module chr_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [1:0]      req_operation,
   input  chr_pkg::sts_type sts,
   output chr_pkg::cmd_type cmd,
   output logic            busy
);
   import chr_pkg::*;
   `include "consistent_hash_ring_top_assert.svh"

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_LOOKUP;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_operation;
               case (req_operation)
                  OP_LOOKUP, OP_ADD: begin
                     cmd.srch_init = 1'b1;
                     state_in      = S_SEARCH;
                  end
                  OP_REMOVE: begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SEARCH: begin
            if (sts.srch_done) begin
               if (op_ff == OP_LOOKUP) begin
                  if (sts.empty) state_in = S_DONE;
                  else begin
                     cmd.lk_rd = 1'b1;
                     state_in  = S_LKRD;
                  end
               end else if (sts.full) begin
                  state_in = S_DONE;
               end else begin
                  cmd.sh_init = 1'b1;
                  state_in    = S_SHIFT;
               end
            end else begin
               cmd.srch_rd = 1'b1;
               state_in    = S_SWAIT;
            end
         end
         S_SWAIT: begin
            cmd.srch_step = 1'b1;
            state_in      = S_SEARCH;
         end
         S_LKRD: state_in = S_DONE;
         S_SHIFT: begin
            cmd.sh_step = 1'b1;
            if (sts.sh_done) state_in = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   `CHR_ASSERT_NXT(a_start_leaves_idle, clock, reset, start && !busy, busy,
                   "start did not make the block busy")
   `CHR_ASSERT_NXT(a_done_to_idle, clock, reset, state_ff == S_DONE, !busy,
                   "done state did not return to idle")
   `CHR_ASSERT_IMP(a_swait_from_search, clock, reset, state_ff == S_SWAIT,
                   $past(state_ff) == S_SEARCH, "search wait entered out of order")
endmodule

FILE: hw/rtl/chr_dpath.sv
// ----------------------------------------------------------------------------
// chr_dpath
// Ring memory, binary search, insert shift and remove compaction.
// ----------------------------------------------------------------------------
module chr_dpath #(
   parameter int RING_DEPTH   = 256,
   parameter int SERVER_COUNT = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  chr_pkg::cmd_type cmd,
   input  logic [1:0]       req_operation,
   input  logic [31:0]      req_key_hash,
   input  logic [31:0]      req_node_point,
   input  logic [3:0]       req_server_tag,
   output chr_pkg::sts_type sts,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_owner_tag,
   output logic [8:0]       rsp_removed_count,
   output logic [8:0]       rsp_ring_size
);
   import chr_pkg::*;
   `include "consistent_hash_ring_top_assert.svh"

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = AW + 1;
   localparam int TW = (SERVER_COUNT > 16) ? $clog2(SERVER_COUNT) : 4;

   // memory of {owner, point}, one write and one read port
   logic [TW+31:0] mem [RING_DEPTH];
   logic [TW+31:0] rd_ff;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [TW+31:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [CW-1:0] ptr_ff, ptr_in, wp_ff, wp_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic          pend_ff, pend_in;
   logic [31:0]   key_ff, pt_ff;
   logic [3:0]    tag_ff;
   logic [1:0]    op_ff;
   logic [3:0]    own_ff, own_in;
   logic          lkv_ff, lkv_in;
   logic [31:0]   rd_pt;
   logic [TW-1:0] rd_tag;
   logic          go_right;
   logic          strobe_ff;
   logic [1:0]    status_ff, status_in;
   logic [3:0]    owner_ff;
   logic [8:0]    removed_ff, size_ff;
   logic          full_hit_ff;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_pt  = rd_ff[31:0];
   assign rd_tag = rd_ff[TW+31:32];
   assign go_right = (op_ff == OP_LOOKUP) ? (rd_pt < key_ff) : (rd_pt <= pt_ff);

   assign sts.srch_done = (lo_ff == hi_ff);
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff >= CW'(RING_DEPTH));
   // shift: ptr walks down from count to lo; at ptr==lo the new point goes in
   assign sts.sh_done   = pend_ff && (ptr_ff == lo_ff);
   assign sts.scan_done = pend_ff && (ptr_ff == count_ff);

   always_comb begin
      lo_in = lo_ff; hi_in = hi_ff; ptr_in = ptr_ff; wp_in = wp_ff;
      rem_in = rem_ff; pend_in = pend_ff; count_in = count_ff;
      own_in = own_ff; lkv_in = lkv_ff;
      rd_addr = '0;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      if (cmd.srch_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.srch_rd) rd_addr = mid[AW-1:0];
      if (cmd.srch_step) begin
         if (go_right) lo_in = mid + CW'(1);
         else hi_in = mid;
      end
      if (cmd.lk_rd) begin
         rd_addr = (lo_ff >= count_ff) ? '0 : lo_ff[AW-1:0];
      end
      if (cmd.sh_init) begin
         ptr_in  = count_ff;
         pend_in = 1'b0;
      end
      if (cmd.sh_step) begin
         // issue the read of ptr-1, write it to ptr in the next cycle
         if (!pend_ff) begin
            if (ptr_ff == lo_ff) pend_in = 1'b1;
            else begin
               rd_addr = AW'(ptr_ff - CW'(1));
               pend_in = 1'b1;
            end
         end else if (ptr_ff == lo_ff) begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[AW-1:0];
            wr_data  = {TW'(tag_ff), pt_ff};
            count_in = count_ff + CW'(1);
         end else begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rd_ff;
            ptr_in  = ptr_ff - CW'(1);
            if (ptr_in != lo_ff) rd_addr = AW'(ptr_in - CW'(1));
         end
      end
      if (cmd.scan_init) begin
         ptr_in = '0; wp_in = '0; rem_in = '0; pend_in = 1'b0;
      end
      if (cmd.scan_step) begin
         // pend_ff: rd_ff holds entry ptr_ff
         rd_addr = ptr_ff[AW-1:0];
         if (!pend_ff) begin
            pend_in = 1'b1;
         end else if (ptr_ff == count_ff) begin
            count_in = wp_ff;
         end else begin
            if (rd_tag == TW'(tag_ff)) rem_in = rem_ff + CW'(1);
            else begin
               wr_en   = 1'b1;
               wr_addr = wp_ff[AW-1:0];
               wr_data = rd_ff;
               wp_in   = wp_ff + CW'(1);
            end
            ptr_in  = ptr_ff + CW'(1);
            rd_addr = ptr_in[AW-1:0];
         end
      end
      if (lkv_ff) begin
         own_in = 4'(rd_tag);
         lkv_in = 1'b0;
      end
      if (cmd.lk_rd) lkv_in = 1'b1;
      if (cmd.load) begin
         own_in = '0;
         lkv_in = 1'b0;
      end
   end

   // a full ring is judged at the request, since a good add may fill it
   always_comb begin
      status_in = ST_OK;
      case (op_ff)
         OP_LOOKUP: if (count_ff == '0) status_in = ST_EMPTY;
         OP_ADD:    if (full_hit_ff) status_in = ST_FULL;
         OP_REMOVE: if (rem_ff == '0) status_in = ST_NOSERVER;
         default:   status_in = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         lkv_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         pend_ff   <= (cmd.sh_init || cmd.scan_init) ? 1'b0 : pend_in;
         lkv_ff    <= lkv_in;
         strobe_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      ptr_ff <= ptr_in;
      wp_ff  <= wp_in;
      rem_ff <= rem_in;
      own_ff <= own_in;
      if (cmd.load) begin
         op_ff       <= req_operation;
         key_ff      <= req_key_hash;
         pt_ff       <= req_node_point;
         tag_ff      <= req_server_tag;
         full_hit_ff <= (req_operation == OP_ADD) && (count_ff >= CW'(RING_DEPTH));
      end
      if (cmd.finish) begin
         status_ff  <= status_in;
         owner_ff   <= (op_ff == OP_LOOKUP && count_ff != '0) ? own_in : 4'd0;
         removed_ff <= (op_ff == OP_REMOVE) ? 9'(rem_ff) : 9'd0;
         size_ff    <= 9'(count_ff);
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_owner_tag     = owner_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_ring_size     = size_ff;

   `CHR_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(RING_DEPTH),
                   "ring count beyond depth")
   `CHR_ASSERT_IMP(a_search_window, clock, reset, cmd.srch_step, lo_ff < hi_ff,
                   "search step on an empty window")
   `CHR_ASSERT_NXT(a_add_grows, clock, reset, sts.sh_done && cmd.sh_step,
                   count_ff == $past(count_ff) + CW'(1), "insert did not grow the ring")
endmodule

FILE: hw/rtl/consistent_hash_ring_top.sv
// ----------------------------------------------------------------------------
// consistent_hash_ring_top
// Sorted ring of hash points with server owners: lookup, add, remove.
// ----------------------------------------------------------------------------
// One word at a time: busy rises at the edge that takes start and falls in the
// cycle that carries the result strobe, so the next word can be taken at the
// end of that cycle. A lookup is a binary search, a read state and a wait
// state per halving over the single read port of the ring memory, with at most
// log2(n)+1 halvings (9 at 256 points); an empty ring is answered without a
// search step. An add searches likewise and then moves each entry above the
// insert point up one place, reading it before writing it back; a full ring
// skips the move. A remove streams the whole ring through the read port once.
// An unused operation code goes straight to the result.
// rsp_strobe lasts one cycle and cannot be held off.
module consistent_hash_ring_top #(
   parameter int RING_DEPTH   = 256,
   parameter int SERVER_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_key_hash,
   input  logic [31:0] req_node_point,
   input  logic [3:0]  req_server_tag,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_owner_tag,
   output logic [8:0]  rsp_removed_count,
   output logic [8:0]  rsp_ring_size
);
   import chr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   chr_ctrl u_ctrl (
      .clock, .reset, .start, .req_operation, .sts, .cmd, .busy
   );

   chr_dpath #(.RING_DEPTH(RING_DEPTH), .SERVER_COUNT(SERVER_COUNT)) u_dpath (
      .clock, .reset, .cmd, .req_operation, .req_key_hash, .req_node_point,
      .req_server_tag, .sts, .rsp_strobe, .rsp_status, .rsp_owner_tag,
      .rsp_removed_count, .rsp_ring_size
   );
endmodule
